// ===== rtl/ptx_pkg.sv =====
// Shared types and constants for the timer-to-microseconds converter.
package ptx_pkg;

    // Running tick total and result widths.
    localparam int TOTAL_BITS = 64;
    localparam int US_BITS    = 63;
    localparam int HALF_BITS  = 32;

    // 1000000 / 3579545 reduces by their common factor 5 to 200000 / 715909.
    // With MAGIC = ceil(2^84 * 200000 / 715909), total * MAGIC overshoots
    // total * 200000 / 715909 * 2^84 by less than total, which is below
    // 2^84 / 715909, so floor(total * MAGIC / 2^84) is the exact quotient
    // for every 64-bit total.
    localparam int              MAGIC_SHIFT = 84;
    localparam int              MAGIC_BITS  = 83;
    localparam logic [127:0]    MAGIC_WIDE  =
        ((128'd1 << MAGIC_SHIFT) * 128'd200000 + 128'd715908) / 128'd715909;
    localparam logic [MAGIC_BITS-1:0] MAGIC = MAGIC_WIDE[MAGIC_BITS-1:0];

    // Width of the top limb of MAGIC above its two 32-bit limbs.
    localparam int MAGIC_TOP_BITS = MAGIC_BITS - 2 * HALF_BITS;

    // Partial sums of weight 2^0 and weight 2^64.
    localparam int LOW_SUM_BITS  = 3 * HALF_BITS + 1;
    localparam int HIGH_SUM_BITS = MAGIC_BITS + 1;

    // Decoupling queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] total;
        logic                  ok;
    } ptx_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ptx_q_status_t;

endpackage

// ===== rtl/ptx_front.sv =====
// Front end: accepts timer samples and extends them into the 64-bit tick total.
module ptx_front #(
    parameter int TIMER_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [TIMER_BITS-1:0] timer_sample,
    input  logic                  sample_ok,
    input  ptx_pkg::ptx_q_status_t q_status,
    output logic                  q_push,
    output ptx_pkg::ptx_entry_t   q_wdata
);

    logic [ptx_pkg::TOTAL_BITS-1:0] tick_total_reg;
    logic [ptx_pkg::TOTAL_BITS-1:0] tick_total_next;
    logic [TIMER_BITS-1:0]          distance;

    // Modular subtraction gives the forward distance, wrap included.
    assign distance = timer_sample - tick_total_reg[TIMER_BITS-1:0];
    assign q_push   = push && !q_status.full;

    always_comb
    begin
        tick_total_next = tick_total_reg;
        if (q_push && sample_ok)
        begin
            tick_total_next = tick_total_reg + ptx_pkg::TOTAL_BITS'(distance);
        end
    end

    assign q_wdata.total = tick_total_next;
    assign q_wdata.ok    = sample_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_total_reg <= '0;
        end
        else
        begin
            tick_total_reg <= tick_total_next;
        end
    end

    // A good sample leaves its value in the low bits of the total.
    a_low_bits_track: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && sample_ok) |=>
            (tick_total_reg[TIMER_BITS-1:0] == $past(timer_sample)))
        else $error("tick total low bits do not match the last good sample");

    // A failed read leaves the total untouched.
    a_failed_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !sample_ok) |=> $stable(tick_total_reg))
        else $error("tick total changed on a failed read");

endmodule

// ===== rtl/ptx_queue.sv =====
// Short first-word-fall-through queue between the front and back ends.
module ptx_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ptx_pkg::ptx_entry_t    wdata,
    input  logic                   pop,
    output ptx_pkg::ptx_entry_t    rdata,
    output ptx_pkg::ptx_q_status_t status
);

    ptx_pkg::ptx_entry_t              entry_reg [0:ptx_pkg::QUEUE_DEPTH-1];
    logic [ptx_pkg::QPTR_BITS-1:0]    wr_ptr_reg;
    logic [ptx_pkg::QPTR_BITS-1:0]    rd_ptr_reg;
    logic [ptx_pkg::QCNT_BITS-1:0]    count_reg;
    logic [ptx_pkg::QCNT_BITS-1:0]    count_next;

    assign status.full  = (count_reg == ptx_pkg::QCNT_BITS'(ptx_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign rdata        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ptx_pkg::QCNT_BITS'(ptx_pkg::QUEUE_DEPTH))
        else $error("queue occupancy exceeds its depth");

    a_no_overflow_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full && !pop) && !(pop && status.empty))
        else $error("queue written while full or read while empty");

endmodule

// ===== rtl/ptx_back.sv =====
// Back end: scales the tick total down to microseconds by reciprocal multiplication.
module ptx_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ptx_pkg::ptx_q_status_t        q_status,
    input  ptx_pkg::ptx_entry_t           q_rdata,
    output logic                          q_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic [ptx_pkg::US_BITS-1:0]   elapsed_microseconds,
    output logic                          ok
);

    localparam int HB = ptx_pkg::HALF_BITS;
    localparam int PB = 2 * ptx_pkg::HALF_BITS;
    localparam int TB = ptx_pkg::MAGIC_TOP_BITS;
    localparam int NB = ptx_pkg::HALF_BITS + ptx_pkg::MAGIC_TOP_BITS;
    localparam int LB = ptx_pkg::LOW_SUM_BITS;
    localparam int SB = ptx_pkg::HIGH_SUM_BITS;
    localparam int UB = ptx_pkg::US_BITS;
    localparam int QS = ptx_pkg::MAGIC_SHIFT - PB;

    // The scaling constant split into two 32-bit limbs and a short top limb.
    localparam logic [HB-1:0] M0 = ptx_pkg::MAGIC[HB-1:0];
    localparam logic [HB-1:0] M1 = ptx_pkg::MAGIC[PB-1:HB];
    localparam logic [TB-1:0] M2 = ptx_pkg::MAGIC[ptx_pkg::MAGIC_BITS-1:PB];

    logic          advance;
    logic [HB-1:0] t_lo;
    logic [HB-1:0] t_hi;

    // Partial-product stage: every product has operands of at most 32 bits.
    logic          mul_vld_reg;
    logic          mul_ok_reg;
    logic [PB-1:0] pp00_reg;
    logic [PB-1:0] pp01_reg;
    logic [PB-1:0] pp10_reg;
    logic [PB-1:0] pp11_reg;
    logic [NB-1:0] pp02_reg;
    logic [NB-1:0] pp12_reg;

    // Partial-sum stage: the products of weight 2^0 and 2^32 in one group,
    // those of weight 2^64 and 2^96 in the other.
    logic          sum_vld_reg;
    logic          sum_ok_reg;
    logic [LB-1:0] sum_lo_reg;
    logic [SB-1:0] sum_hi_reg;
    logic [SB-1:0] upper;

    // Output register.
    logic          out_vld_reg;
    logic          out_ok_reg;
    logic [UB-1:0] out_us_reg;

    // The whole pipeline moves together whenever the output slot frees up.
    assign advance = !out_vld_reg || pop;
    assign q_pop   = advance && !q_status.empty;

    assign t_lo = q_rdata.total[HB-1:0];
    assign t_hi = q_rdata.total[PB-1:HB];

    // Folding the carry out of the low group into the high group gives the
    // full product shifted right by 64; the low 64 bits cannot carry further.
    assign upper = sum_hi_reg + SB'(sum_lo_reg[LB-1:PB]);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pp00_reg    <= PB'(t_lo) * PB'(M0);
            pp01_reg    <= PB'(t_lo) * PB'(M1);
            pp10_reg    <= PB'(t_hi) * PB'(M0);
            pp11_reg    <= PB'(t_hi) * PB'(M1);
            pp02_reg    <= NB'(t_lo) * NB'(M2);
            pp12_reg    <= NB'(t_hi) * NB'(M2);
            mul_ok_reg  <= q_rdata.ok;
            sum_lo_reg  <= LB'(pp00_reg) + LB'({pp01_reg, {HB{1'b0}}})
                         + LB'({pp10_reg, {HB{1'b0}}});
            sum_hi_reg  <= SB'(pp02_reg) + SB'(pp11_reg) + SB'({pp12_reg, {HB{1'b0}}});
            sum_ok_reg  <= mul_ok_reg;
            out_ok_reg  <= sum_ok_reg;
            out_us_reg  <= sum_ok_reg ? upper[QS+UB-1:QS] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            sum_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            mul_vld_reg <= !q_status.empty;
            sum_vld_reg <= mul_vld_reg;
            out_vld_reg <= sum_vld_reg;
        end
    end

    assign empty                = !out_vld_reg;
    assign ok                   = out_ok_reg;
    assign elapsed_microseconds = out_us_reg;

    a_failed_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_ok_reg) |-> (out_us_reg == '0))
        else $error("failed read produced a nonzero time");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !pop) |=>
            (out_vld_reg && $stable(out_us_reg) && $stable(out_ok_reg)))
        else $error("waiting result changed before it was taken");

endmodule

// ===== rtl/pm_timer_extend_to_microseconds.sv =====
// Top level of the power-management timer to microseconds converter.
//
// This block turns samples of a free-running power-management timer that ticks
// at 3579545 Hz into elapsed microseconds. Each sample transaction carries the
// raw timer reading and a flag telling whether the read succeeded. The front end
// keeps a 64-bit running tick total whose low TIMER_BITS bits mirror the last
// good sample; a good sample adds the forward distance to it, which accounts
// for one timer wrap between samples. The back end returns
// floor(total * 1000000 / 3579545) with ok set, or zero with ok clear for a
// failed read, in which case the total is left alone. Both sides behave as
// queues: samples go in with push while full is low, results come out with pop
// while empty is low, in order and exactly one result per sample. The block
// takes one sample per clock cycle while full is low; that rate is set by the
// single 64-bit add in the running-total loop. After a sample is accepted, the
// back end takes its entry from the four-entry queue and registers six partial
// products of the total and a precomputed reciprocal constant (each at most 32
// by 32 bits), then registers two partial sums, and then the output register
// loads the top bits of their combined sum. The back end stalls as a whole only
// while a finished result waits to be popped; the queue then keeps absorbing
// samples until it is full, so up to seven transactions can be in flight.
module pm_timer_extend_to_microseconds #(
    parameter int TIMER_BITS = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [TIMER_BITS-1:0]       timer_sample,
    input  logic                        sample_ok,
    output logic                        empty,
    input  logic                        pop,
    output logic [ptx_pkg::US_BITS-1:0] elapsed_microseconds,
    output logic                        ok
);

    ptx_pkg::ptx_q_status_t q_status;
    ptx_pkg::ptx_entry_t    q_wdata;
    ptx_pkg::ptx_entry_t    q_rdata;
    logic                   q_push;
    logic                   q_pop;

    assign full = q_status.full;

    ptx_front #(
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .timer_sample (timer_sample),
        .sample_ok    (sample_ok),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    ptx_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    ptx_back u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .q_status             (q_status),
        .q_rdata              (q_rdata),
        .q_pop                (q_pop),
        .pop                  (pop),
        .empty                (empty),
        .elapsed_microseconds (elapsed_microseconds),
        .ok                   (ok)
    );

endmodule

// ===== sim/pm_timer_extend_to_microseconds_tb.sv =====
// Self-checking testbench for the timer-to-microseconds converter.
module pm_timer_extend_to_microseconds_tb;

    // The timer width used throughout this run.
    localparam int TIMER_BITS = 24;

    // Conversion constants: ticks per second of the timer and microseconds per second.
    localparam logic [127:0] TIMER_HZ      = 128'd3579545;
    localparam logic [127:0] US_PER_SECOND = 128'd1000000;

    // The tail wait after the last result gives the block ample room.
    localparam int TAIL_CYCLES  = 150;
    localparam int LIMIT_CYCLES = 300000;
    localparam int MAX_REPORTS  = 10;
    localparam int MAX_GAP      = 19;

    // One expected result transaction, field for field as on the result ports.
    typedef struct packed {
        logic [ptx_pkg::US_BITS-1:0] microseconds;
        logic                        time_valid;
    } usec_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        push = 1'b0;
    logic                        full;
    logic [TIMER_BITS-1:0]       timer_sample = '0;
    logic                        sample_ok = 1'b0;
    logic                        empty;
    logic                        pop = 1'b0;
    logic [ptx_pkg::US_BITS-1:0] elapsed_microseconds;
    logic                        ok;

    // Predictor state: the running tick count that the block should hold.
    logic [ptx_pkg::TOTAL_BITS-1:0] running_ticks = '0;
    usec_result_t                   pending_results[$];

    // Idling controls, switched by the tests to vary the traffic shape.
    logic tx_idle = 1'b1;
    logic rx_idle = 1'b1;
    logic rx_holding = 1'b0;
    int   rx_hold_request = 0;

    // Run statistics.
    int   mismatches = 0;
    int   results_checked = 0;
    int   samples_sent = 0;
    int   failed_reads = 0;
    int   timer_wraps = 0;
    int   equal_samples = 0;
    int   full_stalls = 0;
    int   cycle_count = 0;

    pm_timer_extend_to_microseconds #(
        .TIMER_BITS(TIMER_BITS)
    ) u_top (
        .clk                  (clk),
        .rst_n                (rst_n),
        .push                 (push),
        .full                 (full),
        .timer_sample         (timer_sample),
        .sample_ok            (sample_ok),
        .empty                (empty),
        .pop                  (pop),
        .elapsed_microseconds (elapsed_microseconds),
        .ok                   (ok)
    );

    initial
    begin : clock_gen
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Watchdog: a run that stalls or loses results ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results still expected.",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Exact conversion of a tick count to whole microseconds. The product
    // needs about 84 bits, so the whole computation is carried at 128 bits
    // and the quotient is then cut to the result width.
    function automatic logic [ptx_pkg::US_BITS-1:0] scale_to_microseconds(
        input logic [ptx_pkg::TOTAL_BITS-1:0] ticks);
        logic [127:0] scaled;
        scaled = {64'd0, ticks} * US_PER_SECOND;
        scaled = scaled / TIMER_HZ;
        return scaled[ptx_pkg::US_BITS-1:0];
    endfunction

    // Applies one accepted sample to the predictor and returns the result
    // that the block must produce for it. A failed read leaves the count
    // alone and yields zero with the valid flag clear. A good read adds the
    // forward distance from the low bits of the count to the sample; when
    // the sample is below those bits the timer has wrapped once, so a full
    // timer period is added to the distance.
    function automatic usec_result_t advance_running_ticks(
        input logic [TIMER_BITS-1:0] sample,
        input logic                  read_good);
        usec_result_t                   res;
        logic [TIMER_BITS-1:0]          low_bits;
        logic [ptx_pkg::TOTAL_BITS-1:0] distance;
        if (!read_good)
        begin
            failed_reads++;
            res.microseconds = '0;
            res.time_valid   = 1'b0;
            return res;
        end
        low_bits = running_ticks[TIMER_BITS-1:0];
        distance = {{(ptx_pkg::TOTAL_BITS-TIMER_BITS){1'b0}}, sample};
        if (sample < low_bits)
        begin
            distance = distance + (64'd1 << TIMER_BITS);
            timer_wraps++;
        end
        else if (sample == low_bits)
        begin
            equal_samples++;
        end
        distance      = distance - {{(ptx_pkg::TOTAL_BITS-TIMER_BITS){1'b0}}, low_bits};
        running_ticks = running_ticks + distance;
        res.microseconds = scale_to_microseconds(running_ticks);
        res.time_valid   = 1'b1;
        return res;
    endfunction

    // Offers one sample transaction, after a random gap when the sender is
    // idling, and holds it until the block accepts it. The expected result
    // is queued at the edge of acceptance, before the block can answer.
    task automatic send_sample(input logic [TIMER_BITS-1:0] sample, input logic read_good);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        timer_sample <= sample;
        sample_ok    <= read_good;
        @(posedge clk);
        while (full)
        begin
            full_stalls++;
            @(posedge clk);
        end
        pending_results.push_back(advance_running_ticks(sample, read_good));
        samples_sent++;
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_for_results;
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side. Outputs and pop are read at the clock edge, before any
    // update scheduled for that edge, so a transaction is seen exactly when
    // the block sees it. The next pop value is then chosen from the gap drawn
    // for the current result and from any long hold-off in force.
    int rx_gap = 0;

    always @(posedge clk)
    begin
        usec_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result: us=%0d ok=%0b", elapsed_microseconds, ok);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (elapsed_microseconds !== want.microseconds || ok !== want.time_valid)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Mismatch on result %0d: us exp %0d got %0d, ok exp %0b got %0b",
                                 results_checked, want.microseconds, elapsed_microseconds,
                                 want.time_valid, ok);
                end
            end
            rx_gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
        end
        if (rx_holding || rx_gap > 0)
        begin
            if (!rx_holding)
                rx_gap--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    // A long receiver hold-off, counted here so the sender keeps running
    // while results pile up inside the block.
    initial
    begin : rx_hold_timer
        forever
        begin
            wait (rx_hold_request > 0);
            rx_holding = 1'b1;
            repeat (rx_hold_request) @(posedge clk);
            rx_hold_request = 0;
            rx_holding = 1'b0;
        end
    end

    // Directed cases: a failed read straight out of reset, an equal sample
    // at zero, the largest sample, a wrap back to zero, a step to one, a repeat
    // of the current value, alternating bit patterns, a failed read carrying
    // an all-ones sample that must be ignored, and a sample just below the
    // current low bits, which is the longest possible forward distance.
    task automatic test_directed_edges;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_sample(24'h000000, 1'b0);
        send_sample(24'h000000, 1'b1);
        send_sample(24'hFFFFFF, 1'b1);
        send_sample(24'h000000, 1'b1);
        send_sample(24'h000001, 1'b1);
        send_sample(24'h000001, 1'b1);
        send_sample(24'hAAAAAA, 1'b1);
        send_sample(24'h555555, 1'b1);
        send_sample(24'hFFFFFF, 1'b0);
        send_sample(24'h555555, 1'b1);
        send_sample(24'h800000, 1'b1);
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h000000, 1'b0);
        send_sample(24'hFFFFFE, 1'b1);
        send_sample(24'hFFFFFF, 1'b1);
        send_sample(24'hFFFFFF, 1'b1);
    endtask

    // Random traffic in chunks, each chunk with its own idling mix so that
    // gaps land on every stage and some stretches run back to back. Samples
    // mix realistic forward steps from the current count with equal samples,
    // near-full-period steps, arbitrary readings and failed reads.
    task automatic test_random_samples(input int count);
        int                    kind;
        logic [TIMER_BITS-1:0] low_bits;
        logic [TIMER_BITS-1:0] sample;
        logic                  read_good;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            kind      = $urandom_range(0, 99);
            low_bits  = running_ticks[TIMER_BITS-1:0];
            read_good = 1'b1;
            if (kind < 12)
            begin
                sample    = TIMER_BITS'($urandom);
                read_good = 1'b0;
            end
            else if (kind < 20)
                sample = low_bits;
            else if (kind < 30)
                sample = low_bits - TIMER_BITS'($urandom_range(1, 16));
            else if (kind < 60)
                sample = low_bits + TIMER_BITS'($urandom_range(1, 5000));
            else
                sample = TIMER_BITS'($urandom);
            send_sample(sample, read_good);
        end
    endtask

    // Holds the result side for a long stretch while the sender streams
    // without gaps, so the pipeline and its queue fill and full rises.
    task automatic test_backpressure(input int count);
        tx_idle = 1'b0;
        rx_hold_request = 400;
        for (int i = 0; i < count; i++)
            send_sample(running_ticks[TIMER_BITS-1:0] + TIMER_BITS'($urandom_range(0, 300000)),
                        ($urandom_range(0, 7) != 0));
        tx_idle = 1'b1;
    endtask

    // Sends a burst, lets the block drain completely, then sends again.
    task automatic test_drain_pause(input int count);
        for (int i = 0; i < count; i++)
            send_sample(TIMER_BITS'($urandom), ($urandom_range(0, 4) != 0));
        wait_for_results();
        for (int i = 0; i < count; i++)
            send_sample(running_ticks[TIMER_BITS-1:0] + TIMER_BITS'($urandom_range(0, 1000)),
                        1'b1);
    endtask

    initial
    begin : test_sequence
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_backpressure(100);
        test_drain_pause(20);
        test_random_samples(600);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d samples: %0d failed reads, %0d timer wraps, %0d equal samples.",
                 samples_sent, failed_reads, timer_wraps, equal_samples);
        $display("Checked %0d results; input stalled on full for %0d cycles; %0d mismatches.",
                 results_checked, full_stalls, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
